// ===== src/gpioirq_pkg.sv =====
// shared types, register offsets and constants of the gpio interrupt controller
`timescale 1ns / 1ps
package gpioirq_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PIN   = 2'd2
  } op_e;

  // register offsets
  localparam logic [7:0] OFF_REVISION   = 8'h00;
  localparam logic [7:0] OFF_SYSCONFIG  = 8'h10;
  localparam logic [7:0] OFF_SYSSTATUS  = 8'h14;
  localparam logic [7:0] OFF_STATUS0    = 8'h18;
  localparam logic [7:0] OFF_ENABLE0    = 8'h1c;
  localparam logic [7:0] OFF_WAKE_EN    = 8'h20;
  localparam logic [7:0] OFF_STATUS1    = 8'h28;
  localparam logic [7:0] OFF_ENABLE1    = 8'h2c;
  localparam logic [7:0] OFF_CTRL       = 8'h30;
  localparam logic [7:0] OFF_DIRECTION  = 8'h34;
  localparam logic [7:0] OFF_DATA_IN    = 8'h38;
  localparam logic [7:0] OFF_DATA_OUT   = 8'h3c;
  localparam logic [7:0] OFF_LOW_DET    = 8'h40;
  localparam logic [7:0] OFF_HIGH_DET   = 8'h44;
  localparam logic [7:0] OFF_RISE_DET   = 8'h48;
  localparam logic [7:0] OFF_FALL_DET   = 8'h4c;
  localparam logic [7:0] OFF_DEB_LINES  = 8'h50;
  localparam logic [7:0] OFF_DEB_TIME   = 8'h54;
  localparam logic [7:0] OFF_ENABLE0_CLR = 8'h60;
  localparam logic [7:0] OFF_ENABLE0_SET = 8'h64;
  localparam logic [7:0] OFF_ENABLE1_CLR = 8'h70;
  localparam logic [7:0] OFF_ENABLE1_SET = 8'h74;
  localparam logic [7:0] OFF_WAKE_CLR   = 8'h80;
  localparam logic [7:0] OFF_WAKE_SET   = 8'h84;
  localparam logic [7:0] OFF_DOUT_CLR   = 8'h90;
  localparam logic [7:0] OFF_DOUT_SET   = 8'h94;

  localparam logic [31:0] REVISION_VALUE  = 32'h0000_0018;
  localparam logic [31:0] SYSSTATUS_VALUE = 32'h0000_0001;
  localparam logic [4:0]  SYSCFG_MASK     = 5'h1d;
  localparam int unsigned SYSCFG_SOFTRESET_BIT = 1;
  localparam int unsigned SYSCFG_WAKE_BIT      = 2;
  localparam logic [4:0]  SYSCFG_IDLE_MASK     = 5'h18;
  localparam logic [2:0]  CTRL_RESET      = 3'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
    logic [4:0]  pin_index;
    logic        pin_level;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_first;
    logic        irq_second;
    logic        wake_pulse;
    logic [31:0] pin_drive;
    logic [31:0] pin_drive_enable;
    logic        access_error;
  } rsp_t;

endpackage

// ===== src/gpioirq_req_if.sv =====
// request channel: one register access or pin change word per handshake
`timescale 1ns / 1ps
interface gpioirq_req_if;
  logic               valid;
  logic               ready;
  gpioirq_pkg::req_t  payload;

  modport source  (output valid, output payload, input ready);
  modport sink    (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

// ===== src/gpioirq_rsp_if.sv =====
// result channel: one result word per handshake
`timescale 1ns / 1ps
interface gpioirq_rsp_if;
  logic               valid;
  logic               ready;
  gpioirq_pkg::rsp_t  payload;

  modport source  (output valid, output payload, input ready);
  modport sink    (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

// ===== src/gpio_level_edge_irq_controller32_core.sv =====
// gpio block with level and edge interrupt detection, register file and result buffer
//
// Usage: every word on in_i is a register write, a register read or a level
// change on one input pin. Each accepted word yields exactly one word on out_o,
// carrying read data, both interrupt lines, the wake request, the output
// drive values and drive enables, and an access error flag.
// Throughput is one word per cycle while the skid register is empty: all register
// updates are bitwise logic that settles in the same cycle the word is accepted,
// and the result is captured in the output register or the skid register.
// When the receiver stalls, a second (skid) register takes one more result, so
// in_i.ready drops only when both are full; it rises again as soon as out_o
// accepts a word.
// Reset (rst_ni low) clears all registers to their defaults: direction all
// inputs, control two, everything else zero, and empties the result buffer.
// A soft reset through sysconfig restores the same register defaults except for the
// sampled pin inputs and sysconfig (set to the written value); the buffer is kept.
`timescale 1ns / 1ps
module gpio_level_edge_irq_controller32_core #(
  parameter int unsigned LINE_COUNT = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gpioirq_req_if.sink   in_i,
  gpioirq_rsp_if.source out_o
);

  localparam logic [31:0] LineMask  = 32'hFFFF_FFFF >> (32 - LINE_COUNT);
  localparam logic [5:0]  LineCount = 6'(LINE_COUNT);

  logic [31:0] pin_q, pin_d;
  logic [31:0] dout_q, dout_d;
  logic [31:0] dir_q, dir_d;
  logic [31:0] low_q, low_d;
  logic [31:0] high_q, high_d;
  logic [31:0] rise_q, rise_d;
  logic [31:0] fall_q, fall_d;
  logic [31:0] stat0_q, stat0_d;
  logic [31:0] stat1_q, stat1_d;
  logic [31:0] en0_q, en0_d;
  logic [31:0] en1_q, en1_d;
  logic [31:0] wake_en_q, wake_en_d;
  logic [4:0]  sys_q, sys_d;
  logic [2:0]  ctrl_q, ctrl_d;
  logic [31:0] deb_lines_q, deb_lines_d;
  logic [7:0]  deb_time_q, deb_time_d;

  logic              out_valid_q, skid_valid_q;
  gpioirq_pkg::rsp_t out_q, skid_q;
  gpioirq_pkg::rsp_t rsp;

  logic in_fire, out_fire;

  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  always_comb begin
    logic [31:0] v;
    logic [31:0] bit_sel;
    logic [31:0] redet;
    logic        redet0;
    logic        redet1;
    logic        fire;
    logic [31:0] rd;
    logic        err;
    logic        wake;

    v       = in_i.payload.write_data;
    bit_sel = 32'd1 << in_i.payload.pin_index;
    redet0  = 1'b0;
    redet1  = 1'b0;
    fire    = 1'b0;
    rd      = '0;
    err     = 1'b0;
    wake    = 1'b0;

    pin_d       = pin_q;
    dout_d      = dout_q;
    dir_d       = dir_q;
    low_d       = low_q;
    high_d      = high_q;
    rise_d      = rise_q;
    fall_d      = fall_q;
    stat0_d     = stat0_q;
    stat1_d     = stat1_q;
    en0_d       = en0_q;
    en1_d       = en1_q;
    wake_en_d   = wake_en_q;
    sys_d       = sys_q;
    ctrl_d      = ctrl_q;
    deb_lines_d = deb_lines_q;
    deb_time_d  = deb_time_q;

    if (in_fire) begin
      case (gpioirq_pkg::op_e'(in_i.payload.operation))
        gpioirq_pkg::OP_WRITE: begin
          case (in_i.payload.reg_offset)
            gpioirq_pkg::OFF_REVISION, gpioirq_pkg::OFF_SYSSTATUS,
            gpioirq_pkg::OFF_DATA_IN: err = 1'b1;
            gpioirq_pkg::OFF_SYSCONFIG: begin
              if (v[gpioirq_pkg::SYSCFG_SOFTRESET_BIT]) begin
                dout_d      = '0;
                dir_d       = '1;
                low_d       = '0;
                high_d      = '0;
                rise_d      = '0;
                fall_d      = '0;
                stat0_d     = '0;
                stat1_d     = '0;
                en0_d       = '0;
                en1_d       = '0;
                wake_en_d   = '0;
                ctrl_d      = gpioirq_pkg::CTRL_RESET;
                deb_lines_d = '0;
                deb_time_d  = '0;
              end
              sys_d = v[4:0] & gpioirq_pkg::SYSCFG_MASK;
            end
            // clearing a set bit re-arms level detection on that bank
            gpioirq_pkg::OFF_STATUS0: begin
              redet0  = (stat0_q & v) != '0;
              stat0_d = stat0_q & ~v;
            end
            gpioirq_pkg::OFF_STATUS1: begin
              redet1  = (stat1_q & v) != '0;
              stat1_d = stat1_q & ~v;
            end
            gpioirq_pkg::OFF_ENABLE0:     en0_d = v;
            gpioirq_pkg::OFF_ENABLE1:     en1_d = v;
            gpioirq_pkg::OFF_ENABLE0_CLR: en0_d = en0_q & ~v;
            gpioirq_pkg::OFF_ENABLE0_SET: en0_d = en0_q | v;
            gpioirq_pkg::OFF_ENABLE1_CLR: en1_d = en1_q & ~v;
            gpioirq_pkg::OFF_ENABLE1_SET: en1_d = en1_q | v;
            gpioirq_pkg::OFF_WAKE_EN:     wake_en_d = v;
            gpioirq_pkg::OFF_WAKE_CLR:    wake_en_d = wake_en_q & ~v;
            gpioirq_pkg::OFF_WAKE_SET:    wake_en_d = wake_en_q | v;
            gpioirq_pkg::OFF_CTRL:        ctrl_d = v[2:0];
            gpioirq_pkg::OFF_DIRECTION: begin
              dir_d  = v;
              redet0 = 1'b1;
              redet1 = 1'b1;
            end
            gpioirq_pkg::OFF_DATA_OUT:    dout_d = v;
            gpioirq_pkg::OFF_DOUT_CLR:    dout_d = dout_q & ~v;
            gpioirq_pkg::OFF_DOUT_SET:    dout_d = dout_q | v;
            gpioirq_pkg::OFF_LOW_DET: begin
              low_d  = v;
              redet0 = 1'b1;
              redet1 = 1'b1;
            end
            gpioirq_pkg::OFF_HIGH_DET: begin
              high_d = v;
              redet0 = 1'b1;
              redet1 = 1'b1;
            end
            gpioirq_pkg::OFF_RISE_DET:    rise_d = v;
            gpioirq_pkg::OFF_FALL_DET:    fall_d = v;
            gpioirq_pkg::OFF_DEB_LINES:   deb_lines_d = v;
            gpioirq_pkg::OFF_DEB_TIME:    deb_time_d = v[7:0];
            default:                      err = 1'b1;
          endcase
        end
        gpioirq_pkg::OP_READ: begin
          case (in_i.payload.reg_offset)
            gpioirq_pkg::OFF_REVISION:  rd = gpioirq_pkg::REVISION_VALUE;
            gpioirq_pkg::OFF_SYSCONFIG: rd = {27'd0, sys_q};
            gpioirq_pkg::OFF_SYSSTATUS: rd = gpioirq_pkg::SYSSTATUS_VALUE;
            gpioirq_pkg::OFF_STATUS0:   rd = stat0_q;
            gpioirq_pkg::OFF_ENABLE0, gpioirq_pkg::OFF_ENABLE0_CLR,
            gpioirq_pkg::OFF_ENABLE0_SET: rd = en0_q;
            gpioirq_pkg::OFF_WAKE_EN, gpioirq_pkg::OFF_WAKE_CLR,
            gpioirq_pkg::OFF_WAKE_SET:  rd = wake_en_q;
            gpioirq_pkg::OFF_STATUS1:   rd = stat1_q;
            gpioirq_pkg::OFF_ENABLE1, gpioirq_pkg::OFF_ENABLE1_CLR,
            gpioirq_pkg::OFF_ENABLE1_SET: rd = en1_q;
            gpioirq_pkg::OFF_CTRL:      rd = {29'd0, ctrl_q};
            gpioirq_pkg::OFF_DIRECTION: rd = dir_q;
            gpioirq_pkg::OFF_DATA_IN:   rd = pin_q;
            gpioirq_pkg::OFF_DATA_OUT, gpioirq_pkg::OFF_DOUT_CLR,
            gpioirq_pkg::OFF_DOUT_SET:  rd = dout_q;
            gpioirq_pkg::OFF_LOW_DET:   rd = low_q;
            gpioirq_pkg::OFF_HIGH_DET:  rd = high_q;
            gpioirq_pkg::OFF_RISE_DET:  rd = rise_q;
            gpioirq_pkg::OFF_FALL_DET:  rd = fall_q;
            gpioirq_pkg::OFF_DEB_LINES: rd = deb_lines_q;
            gpioirq_pkg::OFF_DEB_TIME:  rd = {24'd0, deb_time_q};
            default:                    err = 1'b1;
          endcase
        end
        gpioirq_pkg::OP_PIN: begin
          // lines past the configured count are ignored
          if ({1'b0, in_i.payload.pin_index} < LineCount) begin
            if (in_i.payload.pin_level) begin
              fire  = (dir_q & bit_sel & ((~pin_q & rise_q) | high_q)) != '0;
              pin_d = pin_q | bit_sel;
            end else begin
              fire  = (dir_q & bit_sel & ((pin_q & fall_q) | low_q)) != '0;
              pin_d = pin_q & ~bit_sel;
            end
            if (fire) begin
              stat0_d = stat0_q | bit_sel;
              stat1_d = stat1_q | bit_sel;
              wake    = sys_q[gpioirq_pkg::SYSCFG_WAKE_BIT] &&
                        ((sys_q & gpioirq_pkg::SYSCFG_IDLE_MASK) != '0) &&
                        ((wake_en_q & bit_sel) != '0);
            end
          end
        end
        default: ;
      endcase
    end

    // level re-detect uses the updated direction and level masks
    redet = dir_d & LineMask & ((pin_d & high_d) | (~pin_d & low_d));
    if (redet0) stat0_d = stat0_d | redet;
    if (redet1) stat1_d = stat1_d | redet;

    rsp.read_data        = rd;
    rsp.irq_first        = (stat0_d & en0_d) != '0;
    rsp.irq_second       = (stat1_d & en1_d) != '0;
    rsp.wake_pulse       = wake;
    rsp.pin_drive        = dout_d & LineMask;
    rsp.pin_drive_enable = ~dir_d & LineMask;
    rsp.access_error     = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q       <= '0;
      dout_q      <= '0;
      dir_q       <= '1;
      low_q       <= '0;
      high_q      <= '0;
      rise_q      <= '0;
      fall_q      <= '0;
      stat0_q     <= '0;
      stat1_q     <= '0;
      en0_q       <= '0;
      en1_q       <= '0;
      wake_en_q   <= '0;
      sys_q       <= '0;
      ctrl_q      <= gpioirq_pkg::CTRL_RESET;
      deb_lines_q <= '0;
      deb_time_q  <= '0;
    end else begin
      pin_q       <= pin_d;
      dout_q      <= dout_d;
      dir_q       <= dir_d;
      low_q       <= low_d;
      high_q      <= high_d;
      rise_q      <= rise_d;
      fall_q      <= fall_d;
      stat0_q     <= stat0_d;
      stat1_q     <= stat1_d;
      en0_q       <= en0_d;
      en1_q       <= en1_d;
      wake_en_q   <= wake_en_d;
      sys_q       <= sys_d;
      ctrl_q      <= ctrl_d;
      deb_lines_q <= deb_lines_d;
      deb_time_q  <= deb_time_d;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!in_fire) begin
        out_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= rsp;
      end
    end else if (in_fire) begin
      if (out_valid_q) begin
        skid_q <= rsp;
      end else begin
        out_q <= rsp;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

// ===== src/gpioirq_checker.sv =====
// port-level assertions for the gpio interrupt controller, bound to the top level
`timescale 1ns / 1ps
module gpioirq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input gpioirq_pkg::rsp_t out_payload_i
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("stalled result word changed");

  // after an accepted word a result word is pending in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted word produced no result");

  // back-pressure only while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty result buffer");

  // an access error never carries read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.access_error |-> out_payload_i.read_data == '0)
    else $error("read data on access error");

endmodule

bind gpio_level_edge_irq_controller32_core gpioirq_checker u_gpioirq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
